[hw/rtl/urlencoded_form_tokenizer_defines.svh]
// Assertion macros used by the checker file.
`ifndef URLENCODED_FORM_TOKENIZER_DEFINES_SVH
`define URLENCODED_FORM_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define UFT_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define UFT_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

[hw/rtl/uft_pkg.sv]
package uft_pkg;

    localparam int MAX_DATA = 3;

    typedef struct packed {
        logic [MAX_DATA-1:0][7:0] data;
        logic [1:0]               ndata;
        logic                     value_side;
        logic                     pair_done;
        logic                     string_done;
    } bundle_t;

endpackage

[hw/rtl/urlencoded_form_tokenizer.sv]
// Channel   Handshake            Payload
// input     in_valid / in_stall  raw_byte, final_byte
// output    out_valid / out_stall decoded_byte, carries_byte, in_value_part,
//                                pair_done, string_done
//
// A byte is decoded in the cycle it is accepted and its results are queued as one request.
// The output register sends one result per cycle while out_stall is low, so input runs at
// one byte per cycle as long as each byte yields at most one result; extra results drain
// from the queue. Reset clears the decoder state, the queue and the output valid at once.
// The input stalls only while the queue of QUEUE_DEPTH requests is full.
module urlencoded_form_tokenizer
    import uft_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] raw_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] decoded_byte,
    output logic       carries_byte,
    output logic       in_value_part,
    output logic       pair_done,
    output logic       string_done
);

    bundle_t front_bundle;
    bundle_t head;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    logic    accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    uft_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .raw_byte   (raw_byte),
        .final_byte (final_byte),
        .push       (push),
        .bundle     (front_bundle)
    );

    uft_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_bundle),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    uft_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .decoded_byte  (decoded_byte),
        .carries_byte  (carries_byte),
        .in_value_part (in_value_part),
        .pair_done     (pair_done),
        .string_done   (string_done)
    );

endmodule

[hw/rtl/uft_front.sv]
module uft_front
    import uft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] raw_byte,
    input  logic       final_byte,
    output logic       push,
    output bundle_t    bundle
);

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return r;
    endfunction

    logic       value_side_reg, value_side_next;
    logic       pair_open_reg, pair_open_next;
    logic [1:0] escape_count_reg, escape_count_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic [7:0] high_char_reg, high_char_next;

    logic [4:0]               hex;
    logic                     do_plain;
    logic [1:0]               nd;
    logic [MAX_DATA-1:0][7:0] dat;
    logic                     pd;
    logic                     sd;

    always_comb
    begin
        hex               = nibble_of(raw_byte);
        value_side_next   = value_side_reg;
        pair_open_next    = pair_open_reg;
        escape_count_next = escape_count_reg;
        high_nibble_next  = high_nibble_reg;
        high_char_next    = high_char_reg;
        do_plain          = 1'b0;
        nd                = 2'd0;
        dat               = '0;
        pd                = 1'b0;
        sd                = 1'b0;

        unique case (escape_count_reg)
            ESC_PCT:
            begin
                if (hex[4])
                begin
                    high_nibble_next  = hex[3:0];
                    high_char_next    = raw_byte;
                    escape_count_next = ESC_DIGIT;
                end
                else
                begin
                    escape_count_next = ESC_NONE;
                    dat[nd]           = CHAR_PERCENT;
                    nd                = nd + 2'd1;
                    do_plain          = 1'b1;
                end
            end
            ESC_DIGIT:
            begin
                escape_count_next = ESC_NONE;
                if (hex[4])
                begin
                    dat[nd] = {high_nibble_reg, hex[3:0]};
                    nd      = nd + 2'd1;
                end
                else
                begin
                    dat[nd]  = CHAR_PERCENT;
                    nd       = nd + 2'd1;
                    dat[nd]  = high_char_reg;
                    nd       = nd + 2'd1;
                    do_plain = 1'b1;
                end
            end
            default:
            begin
                escape_count_next = ESC_NONE;
                do_plain          = 1'b1;
            end
        endcase

        if (do_plain)
        begin
            if (raw_byte == CHAR_AMP)
            begin
                pd              = pair_open_next;
                value_side_next = 1'b0;
                pair_open_next  = 1'b0;
            end
            else
            begin
                pair_open_next = 1'b1;
                if (raw_byte == CHAR_EQUALS && !value_side_next)
                begin
                    value_side_next = 1'b1;
                end
                else if (raw_byte == CHAR_PERCENT)
                begin
                    escape_count_next = ESC_PCT;
                end
                else
                begin
                    dat[nd] = (raw_byte == CHAR_PLUS) ? CHAR_SPACE : raw_byte;
                    nd      = nd + 2'd1;
                end
            end
        end

        if (final_byte)
        begin
            if (escape_count_next == ESC_PCT)
            begin
                dat[nd] = CHAR_PERCENT;
                nd      = nd + 2'd1;
            end
            else if (escape_count_next == ESC_DIGIT)
            begin
                dat[nd] = CHAR_PERCENT;
                nd      = nd + 2'd1;
                dat[nd] = high_char_next;
                nd      = nd + 2'd1;
            end
            if (pair_open_next)
            begin
                pd = 1'b1;
            end
            sd                = 1'b1;
            value_side_next   = 1'b0;
            pair_open_next    = 1'b0;
            escape_count_next = ESC_NONE;
            high_nibble_next  = 4'd0;
            high_char_next    = 8'd0;
        end
    end

    assign bundle.data        = dat;
    assign bundle.ndata       = nd;
    assign bundle.value_side  = value_side_reg;
    assign bundle.pair_done   = pd;
    assign bundle.string_done = sd;
    assign push               = accept && (nd != 2'd0 || pd || sd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_side_reg   <= 1'b0;
            pair_open_reg    <= 1'b0;
            escape_count_reg <= ESC_NONE;
            high_nibble_reg  <= 4'd0;
            high_char_reg    <= 8'd0;
        end
        else if (accept)
        begin
            value_side_reg   <= value_side_next;
            pair_open_reg    <= pair_open_next;
            escape_count_reg <= escape_count_next;
            high_nibble_reg  <= high_nibble_next;
            high_char_reg    <= high_char_next;
        end
    end

endmodule

[hw/rtl/uft_queue.sv]
module uft_queue
    import uft_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t head,
    output logic    full,
    output logic    empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         entries [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign head  = entries[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/uft_back.sv]
module uft_back
    import uft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bundle_t    head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] decoded_byte,
    output logic       carries_byte,
    output logic       in_value_part,
    output logic       pair_done,
    output logic       string_done
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] decoded_byte_reg, decoded_byte_next;
    logic       carries_byte_reg, carries_byte_next;
    logic       in_value_part_reg, in_value_part_next;
    logic       pair_done_reg, pair_done_next;
    logic       string_done_reg, string_done_next;

    logic [2:0] total;
    logic       load;

    always_comb
    begin
        total = {1'b0, head.ndata} + {2'b00, head.pair_done} + {2'b00, head.string_done};
        load  = !empty && (!out_valid_reg || !out_stall);
        pop   = load && (idx_reg == total - 3'd1);

        idx_next           = idx_reg;
        out_valid_next     = out_valid_reg && out_stall;
        decoded_byte_next  = decoded_byte_reg;
        carries_byte_next  = carries_byte_reg;
        in_value_part_next = in_value_part_reg;
        pair_done_next     = pair_done_reg;
        string_done_next   = string_done_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = pop ? 3'd0 : idx_reg + 3'd1;
            if (idx_reg < {1'b0, head.ndata})
            begin
                decoded_byte_next  = head.data[idx_reg[1:0]];
                carries_byte_next  = 1'b1;
                in_value_part_next = head.value_side;
                pair_done_next     = 1'b0;
                string_done_next   = 1'b0;
            end
            else
            begin
                decoded_byte_next  = 8'd0;
                carries_byte_next  = 1'b0;
                in_value_part_next = 1'b0;
                pair_done_next     = head.pair_done && (idx_reg == {1'b0, head.ndata});
                string_done_next   = !pair_done_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        decoded_byte_reg  <= decoded_byte_next;
        carries_byte_reg  <= carries_byte_next;
        in_value_part_reg <= in_value_part_next;
        pair_done_reg     <= pair_done_next;
        string_done_reg   <= string_done_next;
    end

    assign out_valid     = out_valid_reg;
    assign decoded_byte  = decoded_byte_reg;
    assign carries_byte  = carries_byte_reg;
    assign in_value_part = in_value_part_reg;
    assign pair_done     = pair_done_reg;
    assign string_done   = string_done_reg;

endmodule

[hw/rtl/uft_checker.sv]
`include "urlencoded_form_tokenizer_defines.svh"

module uft_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] raw_byte,
    input logic       final_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] decoded_byte,
    input logic       carries_byte,
    input logic       in_value_part,
    input logic       pair_done,
    input logic       string_done
);

    `UFT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(raw_byte) && $stable(final_byte))
    `UFT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(decoded_byte) && $stable(carries_byte) && $stable(string_done))
    `UFT_ASSERT_IMPLY(a_marker_one_flag, clk, rst_n, out_valid && !carries_byte, pair_done != string_done)
    `UFT_ASSERT_IMPLY(a_data_no_flags, clk, rst_n, out_valid && carries_byte, !pair_done && !string_done)
    `UFT_ASSERT_IMPLY(a_marker_clean, clk, rst_n, out_valid && !carries_byte, decoded_byte == 8'd0 && !in_value_part)

endmodule

bind urlencoded_form_tokenizer uft_checker u_checker (.*);

[bench/tb_urlencoded_form_tokenizer.sv]
`timescale 1ns / 100ps

module tb_urlencoded_form_tokenizer;

    localparam logic [7:0] PERCENT = 8'h25;
    localparam logic [7:0] PLUS    = 8'h2B;
    localparam logic [7:0] AMP     = 8'h26;
    localparam logic [7:0] EQUALS  = 8'h3D;
    localparam logic [7:0] SPACE   = 8'h20;

    localparam int ESC_NONE  = 0;
    localparam int ESC_PCT   = 1;
    localparam int ESC_DIGIT = 2;

    localparam int DIRECTED_BYTES = 25;
    localparam int RANDOM_BYTES   = 400;
    localparam int MAX_WAIT       = 11;

    typedef struct packed {
        logic [7:0] raw;
        logic       fin;
    } request_t;

    typedef struct packed {
        logic [7:0] octet;
        logic       data;
        logic       value;
        logic       pair_end;
        logic       string_end;
    } token_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] raw_byte = 8'h00;
    logic       final_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] decoded_byte;
    logic       carries_byte;
    logic       in_value_part;
    logic       pair_done;
    logic       string_done;

    request_t pending[$];
    token_t   expected_tokens[$];

    logic       key_done;
    logic       pair_started;
    int         esc_state;
    logic [3:0] esc_nibble;
    logic [7:0] esc_char;

    int  total_requests = 0;
    int  accepted_requests = 0;
    int  mismatches = 0;
    int  in_wait = 0;
    int  out_wait = 0;
    bit  in_burst = 1'b0;
    bit  out_burst = 1'b0;

    urlencoded_form_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .raw_byte      (raw_byte),
        .final_byte    (final_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .decoded_byte  (decoded_byte),
        .carries_byte  (carries_byte),
        .in_value_part (in_value_part),
        .pair_done     (pair_done),
        .string_done   (string_done)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void clear_decoder();
        key_done = 1'b0;
        pair_started = 1'b0;
        esc_state = ESC_NONE;
        esc_nibble = 4'h0;
        esc_char = 8'h00;
    endfunction

    function automatic void push_data(input logic [7:0] c);
        token_t t;
        t.octet = c;
        t.data = 1'b1;
        t.value = key_done;
        t.pair_end = 1'b0;
        t.string_end = 1'b0;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void push_marker(input logic pair_end, input logic string_end);
        token_t t;
        t.octet = 8'h00;
        t.data = 1'b0;
        t.value = 1'b0;
        t.pair_end = pair_end;
        t.string_end = string_end;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void decode_plain(input logic [7:0] c);
        if (c == AMP)
        begin
            if (pair_started)
                push_marker(1'b1, 1'b0);
            key_done = 1'b0;
            pair_started = 1'b0;
            return;
        end
        pair_started = 1'b1;
        if (c == EQUALS && !key_done)
            key_done = 1'b1;
        else if (c == PERCENT)
            esc_state = ESC_PCT;
        else if (c == PLUS)
            push_data(SPACE);
        else
            push_data(c);
    endfunction

    function automatic void predict_request(input logic [7:0] c, input logic fin);
        int h;
        h = digit_value(c);
        if (esc_state == ESC_PCT)
        begin
            if (h >= 0)
            begin
                esc_nibble = h[3:0];
                esc_char = c;
                esc_state = ESC_DIGIT;
            end
            else
            begin
                esc_state = ESC_NONE;
                push_data(PERCENT);
                decode_plain(c);
            end
        end
        else if (esc_state == ESC_DIGIT)
        begin
            esc_state = ESC_NONE;
            if (h >= 0)
                push_data({esc_nibble, h[3:0]});
            else
            begin
                push_data(PERCENT);
                push_data(esc_char);
                decode_plain(c);
            end
        end
        else
        begin
            esc_state = ESC_NONE;
            decode_plain(c);
        end
        if (fin)
        begin
            if (esc_state == ESC_PCT)
                push_data(PERCENT);
            else if (esc_state == ESC_DIGIT)
            begin
                push_data(PERCENT);
                push_data(esc_char);
            end
            if (pair_started)
                push_marker(1'b1, 1'b0);
            push_marker(1'b0, 1'b1);
            clear_decoder();
        end
    endfunction

    task automatic push_raw(input logic [7:0] c);
        request_t r;
        r.raw = c;
        r.fin = 1'b0;
        pending.insert(pending.size(), r);
    endtask

    task automatic end_string();
        pending[pending.size() - 1].fin = 1'b1;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_raw(s[i]);
        end_string();
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10)
            return 8'("0" + v);
        if ($urandom_range(0, 1) == 0)
            return 8'("a" + v - 10);
        return 8'("A" + v - 10);
    endfunction

    task automatic push_piece();
        int mode;
        mode = $urandom_range(0, 19);
        if (mode < 10)
        begin
            case ($urandom_range(0, 2))
                0: push_raw(8'("a" + $urandom_range(0, 25)));
                1: push_raw(8'("A" + $urandom_range(0, 25)));
                default: push_raw(8'("0" + $urandom_range(0, 9)));
            endcase
        end
        else if (mode < 12)
            push_raw(PLUS);
        else if (mode < 15)
        begin
            push_raw(PERCENT);
            push_raw(hex_char($urandom_range(0, 15)));
            push_raw(hex_char($urandom_range(0, 15)));
        end
        else if (mode == 15)
            push_raw(EQUALS);
        else if (mode < 18)
            push_raw(8'($urandom_range(0, 255)));
        else if (mode == 18)
        begin
            push_raw(PERCENT);
            push_raw(8'($urandom_range(0, 255)));
        end
        else
        begin
            push_raw(PERCENT);
            push_raw(hex_char($urandom_range(0, 15)));
            push_raw(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic push_random_string();
        int start;
        int pairs;
        start = pending.size();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                push_raw(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 5) == 0)
                push_raw(AMP);
            pairs = $urandom_range(1, 4);
            for (int p = 0; p < pairs; p++)
            begin
                if (p > 0)
                begin
                    push_raw(AMP);
                    if ($urandom_range(0, 7) == 0)
                        push_raw(AMP);
                end
                repeat ($urandom_range(0, 4))
                    push_piece();
                if ($urandom_range(0, 4) != 0)
                begin
                    push_raw(EQUALS);
                    repeat ($urandom_range(0, 5))
                        push_piece();
                end
            end
            case ($urandom_range(0, 11))
                0: push_raw(AMP);
                1: push_raw(PERCENT);
                2:
                begin
                    push_raw(PERCENT);
                    push_raw(hex_char($urandom_range(0, 15)));
                end
                default: ;
            endcase
        end
        if (pending.size() == start)
            push_raw("a");
        end_string();
    endtask

    always @(posedge clk)
    begin
        request_t next_req;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_request(raw_byte, final_byte);
                accepted_requests++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_wait > 0)
                begin
                    in_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    next_req = pending.pop_front();
                    raw_byte <= next_req.raw;
                    final_byte <= next_req.fin;
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        in_burst = !in_burst;
                    in_wait = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: byte %h data %b value %b pair %b string %b",
                                 decoded_byte, carries_byte, in_value_part, pair_done,
                                 string_done);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (decoded_byte !== want.octet || carries_byte !== want.data ||
                        in_value_part !== want.value || pair_done !== want.pair_end ||
                        string_done !== want.string_end)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result mismatch: expected %h/%b/%b/%b/%b got %h/%b/%b/%b/%b",
                                     want.octet, want.data, want.value, want.pair_end,
                                     want.string_end, decoded_byte, carries_byte,
                                     in_value_part, pair_done, string_done);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    out_burst = !out_burst;
                out_wait = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
                if (out_wait > 0)
                    out_stall <= 1'b1;
            end
            else if (out_wait > 0)
            begin
                out_wait--;
                if (out_wait == 0)
                    out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        clear_decoder();
        push_text("k%4a=%FF+=");
        push_text("&&%x&");
        push_text("%A&");
        push_raw(8'h00);
        push_raw(8'hFF);
        push_raw(PERCENT);
        end_string();
        push_text("=%7");
        push_text("&");
        while (pending.size() < DIRECTED_BYTES + RANDOM_BYTES)
            push_random_string();
        total_requests = pending.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_requests < total_requests)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/uft_pkg.sv
hw/rtl/uft_front.sv
hw/rtl/uft_queue.sv
hw/rtl/uft_back.sv
hw/rtl/urlencoded_form_tokenizer.sv
hw/rtl/uft_checker.sv
bench/tb_urlencoded_form_tokenizer.sv
